@@ rtl/drco_pkg.sv @@
// Package for the diamond ring cell order block: request codes, register
// indexes, controller states and the controller/datapath command and status.
// No dependencies.
`default_nettype none

package drco_pkg;

  localparam int CoordW  = 12;  // signed walk coordinate, covers the widest ring
  localparam int DimW    = 8;
  localparam int CountW  = 16;
  localparam int CfgIdxW = 1;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_GRID_COLS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WALK,
    ST_HOLD
  } drco_state_t;

  typedef struct packed {
    logic load_req;
    logic do_start;
    logic do_err;
    logic do_step;
    logic push_out;
  } drco_cmd_t;

  typedef struct packed {
    logic req_type;
    logic walk_active;
    logic found;
  } drco_status_t;

endpackage

`default_nettype wire

@@ rtl/drco_if.sv @@
// Channel interfaces: request, result and configuration write.
// Depends on drco_pkg for widths.
`default_nettype none

interface drco_req_if;
  import drco_pkg::*;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [6:0] center_row;
  logic [6:0] center_col;
  modport source (output valid, req_type, center_row, center_col, input ready);
  modport sink   (input valid, req_type, center_row, center_col, output ready);
endinterface

interface drco_res_if;
  logic       valid;
  logic       ready;
  logic [6:0] cell_row;
  logic [6:0] cell_col;
  logic       cell_valid;
  logic       last_cell;
  logic       request_error;
  modport source (output valid, cell_row, cell_col, cell_valid, last_cell, request_error,
                  input ready);
  modport sink   (input valid, cell_row, cell_col, cell_valid, last_cell, request_error,
                  output ready);
endinterface

interface drco_cfg_if;
  import drco_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DimW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/drco_ctrl.sv @@
// Controller for the diamond ring cell order block: request sequencing and
// output register handshake. Depends on drco_pkg.
`default_nettype none

module drco_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     out_ready,
  input  wire drco_pkg::drco_status_t status,
  output drco_pkg::drco_cmd_t     cmd
);
  import drco_pkg::*;

  drco_state_t state, state_next;
  logic        out_free;
  logic        out_valid_next;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (status.req_type == REQ_NEXT && status.walk_active) state_next = ST_WALK;
        else state_next = ST_HOLD;
      end
      ST_WALK:   if (status.found) state_next = ST_HOLD;
      ST_HOLD:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      ST_DECIDE: begin
        cmd.do_start = (status.req_type == REQ_START);
        cmd.do_err   = (status.req_type == REQ_NEXT) && !status.walk_active;
      end
      ST_WALK:   cmd.do_step  = 1'b1;
      ST_HOLD:   cmd.push_out = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.push_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/drco_dp.sv @@
// Datapath for the diamond ring cell order block: grid size registers, walk
// position and leg, cell count, pending result and output register.
// Depends on drco_pkg.
`default_nettype none

module drco_dp #(
  parameter int MAX_DIM = 128
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_we,
  input  wire [drco_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire [drco_pkg::DimW-1:0]       cfg_data,
  input  wire                            in_req_type,
  input  wire [6:0]                      in_center_row,
  input  wire [6:0]                      in_center_col,
  input  wire drco_pkg::drco_cmd_t       cmd,
  output drco_pkg::drco_status_t         status,
  output logic [6:0]                     cell_row,
  output logic [6:0]                     cell_col,
  output logic                           cell_valid,
  output logic                           last_cell,
  output logic                           request_error
);
  import drco_pkg::*;

  localparam int          ClampV   = (MAX_DIM > 255) ? 255 : MAX_DIM;
  localparam logic [DimW-1:0] ClampDim = DimW'(ClampV);
  localparam logic signed [CoordW-1:0] StepOne = CoordW'(1);

  logic [DimW-1:0]          grid_rows, grid_cols;
  logic [DimW-1:0]          lat_rows, lat_cols;
  logic                     req_type_q;
  logic [6:0]               cr_q, cc_q;
  logic signed [CoordW-1:0] walk_row, walk_col;
  logic signed [CoordW-1:0] centre_row_held, centre_col_held;
  logic [1:0]               leg_index;
  logic [CountW-1:0]        cells_emitted, total;
  logic                     walk_active;

  logic [6:0]               res_row, res_col;
  logic                     res_valid, res_last, res_err;

  logic signed [CoordW-1:0] row_next, col_next;
  logic [1:0]               leg_next;
  logic                     got, pos_in_grid, found;
  logic signed [CoordW-1:0] rows_s, cols_s;
  logic                     centre_ok;
  logic [CountW-1:0]        total_now, emitted_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= DimW'(1);
      grid_cols <= DimW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows <= cfg_data;
        REG_GRID_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows_s      = $signed({{(CoordW-DimW){1'b0}}, lat_rows});
  assign cols_s      = $signed({{(CoordW-DimW){1'b0}}, lat_cols});
  assign centre_ok   = ({1'b0, cr_q} < lat_rows) && ({1'b0, cc_q} < lat_cols);
  assign total_now   = CountW'(lat_rows) * CountW'(lat_cols);
  assign emitted_inc = cells_emitted + CountW'(1);

  // one step of the diamond walk
  always_comb begin
    row_next = walk_row;
    col_next = walk_col;
    leg_next = leg_index;
    got      = 1'b0;
    case (leg_index)
      2'd0: begin
        if (walk_row < centre_row_held) begin
          row_next = walk_row + StepOne; col_next = walk_col - StepOne; got = 1'b1;
        end else leg_next = 2'd1;
      end
      2'd1: begin
        if (walk_col < centre_col_held) begin
          row_next = walk_row + StepOne; col_next = walk_col + StepOne; got = 1'b1;
        end else leg_next = 2'd2;
      end
      2'd2: begin
        if (walk_row > centre_row_held) begin
          row_next = walk_row - StepOne; col_next = walk_col + StepOne; got = 1'b1;
        end else leg_next = 2'd3;
      end
      default: begin
        if (walk_col > centre_col_held) begin
          row_next = walk_row - StepOne; col_next = walk_col - StepOne; got = 1'b1;
        end else begin
          row_next = walk_row - StepOne; leg_next = 2'd0;
        end
      end
    endcase
  end

  assign pos_in_grid = !walk_row[CoordW-1] && !walk_col[CoordW-1] &&
                       (walk_row < rows_s) && (walk_col < cols_s);
  assign found       = got && pos_in_grid;

  assign status.req_type    = req_type_q;
  assign status.walk_active = walk_active;
  assign status.found       = found;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active     <= 1'b0;
      lat_rows        <= '0;
      lat_cols        <= '0;
      walk_row        <= '0;
      walk_col        <= '0;
      centre_row_held <= '0;
      centre_col_held <= '0;
      leg_index       <= '0;
      cells_emitted   <= '0;
      total           <= '0;
    end else begin
      if (cmd.load_req && in_req_type == REQ_START) begin
        lat_rows <= (grid_rows > ClampDim) ? ClampDim : grid_rows;
        lat_cols <= (grid_cols > ClampDim) ? ClampDim : grid_cols;
      end
      if (cmd.do_start) begin
        total <= total_now;
        if (!centre_ok) begin
          walk_active <= 1'b0;
        end else begin
          centre_row_held <= $signed({{(CoordW-7){1'b0}}, cr_q});
          centre_col_held <= $signed({{(CoordW-7){1'b0}}, cc_q});
          walk_row        <= $signed({{(CoordW-7){1'b0}}, cr_q}) - StepOne;
          walk_col        <= $signed({{(CoordW-7){1'b0}}, cc_q});
          leg_index       <= 2'd0;
          cells_emitted   <= CountW'(1);
          walk_active     <= (total_now > CountW'(1));
        end
      end
      if (cmd.do_step) begin
        walk_row  <= row_next;
        walk_col  <= col_next;
        leg_index <= leg_next;
        if (found) begin
          cells_emitted <= emitted_inc;
          if (emitted_inc >= total) walk_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_q <= in_req_type;
      cr_q       <= in_center_row;
      cc_q       <= in_center_col;
    end
    if (cmd.do_start) begin
      res_row   <= centre_ok ? cr_q : 7'd0;
      res_col   <= centre_ok ? cc_q : 7'd0;
      res_valid <= centre_ok;
      res_last  <= centre_ok && (total_now <= CountW'(1));
      res_err   <= !centre_ok;
    end
    if (cmd.do_err) begin
      res_row   <= 7'd0;
      res_col   <= 7'd0;
      res_valid <= 1'b0;
      res_last  <= 1'b0;
      res_err   <= 1'b1;
    end
    if (cmd.do_step && found) begin
      res_row   <= walk_row[6:0];
      res_col   <= walk_col[6:0];
      res_valid <= 1'b1;
      res_last  <= (emitted_inc >= total);
      res_err   <= 1'b0;
    end
    if (cmd.push_out) begin
      cell_row      <= res_row;
      cell_col      <= res_col;
      cell_valid    <= res_valid;
      last_cell     <= res_last;
      request_error <= res_err;
    end
  end

endmodule

`default_nettype wire

@@ rtl/diamond_ring_cell_order.sv @@
// Top level of the diamond ring cell order block: emits grid cells in order of
// Manhattan distance from a centre. Depends on drco_pkg, drco_if, drco_ctrl, drco_dp.
//
//   port   dir   handshake      payload
//   req    in    valid/ready    req_type, center_row, center_col
//   res    out   valid/ready    cell_row, cell_col, cell_valid, last_cell, request_error
//   cfg    in    valid/ready    index (0 grid_rows, 1 grid_cols), data
//
// A start or a refused request passes the decide state, then waits in the hold state
// until the output register is free to take the result; then the next request is taken.
// A next request also runs walk steps in the walk state: the step that finds the cell,
// each skipped off-grid position and each leg turn of the diamond walk.
// Synchronous reset; grid size resets to 1x1 with no walk active.
// A new request is taken while the previous result waits in the output register.
`default_nettype none

module diamond_ring_cell_order #(
  parameter int MAX_DIM = 128
) (
  input  wire         clk,
  input  wire         rst,
  drco_req_if.sink    req,
  drco_res_if.source  res,
  drco_cfg_if.sink    cfg
);
  import drco_pkg::*;

  drco_cmd_t    cmd;
  drco_status_t status;

  assign cfg.ready = 1'b1;

  drco_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  drco_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .in_req_type   (req.req_type),
    .in_center_row (req.center_row),
    .in_center_col (req.center_col),
    .cmd           (cmd),
    .status        (status),
    .cell_row      (res.cell_row),
    .cell_col      (res.cell_col),
    .cell_valid    (res.cell_valid),
    .last_cell     (res.last_cell),
    .request_error (res.request_error)
  );

  a_valid_xor_err: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.cell_valid != res.request_error))
    else $error("result is neither a cell nor an error");

  a_last_has_cell: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.last_cell) |-> res.cell_valid)
    else $error("last flag on a result without a cell");

  a_rise_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(cmd.push_out))
    else $error("result appeared without a push");

  a_no_step_and_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.do_step && cmd.load_req))
    else $error("request taken during a walk");

endmodule

`default_nettype wire

@@ tb/sv/drco_order_check.sv @@
// Order checker for the diamond ring cell order block: predicts each result from
// the accepted requests and register writes, and compares every accepted result.
// Depends on drco_pkg and the channel interfaces in drco_if.
module drco_order_check (
  input  wire   clk,
  input  wire   rst,
  drco_req_if   req,
  drco_res_if   res,
  drco_cfg_if   cfg,
  output int    fails,
  output int    pending
);
  import drco_pkg::*;

  typedef enum logic [1:0] {
    LEG_DOWN_LEFT,
    LEG_DOWN_RIGHT,
    LEG_UP_RIGHT,
    LEG_UP_LEFT
  } leg_t;

  typedef struct packed {
    logic [6:0] row;
    logic [6:0] col;
    logic       shown;
    logic       last;
    logic       fault;
  } cell_out_t;

  localparam int MaxDim    = 128;

  logic [DimW-1:0] rows_reg;
  logic [DimW-1:0] cols_reg;
  int              lat_rows;
  int              lat_cols;
  int              pos_row;
  int              pos_col;
  int              hub_row;
  int              hub_col;
  int              emitted;
  leg_t            leg;
  bit              walking;
  int              miss_count;
  cell_out_t       expected_cells[$];
  cell_out_t       head_cell;
  cell_out_t       new_cell;

  assign fails = miss_count;

  function automatic int dim_limit(logic [DimW-1:0] v);
    return (v > MaxDim) ? MaxDim : int'(v);
  endfunction

  function automatic bit on_grid(int r, int c);
    return r >= 0 && r < lat_rows && c >= 0 && c < lat_cols;
  endfunction

  // walk the diamond until an in-grid position turns up
  task automatic step_walk(output int r, output int c);
    bit found;
    bit got;
    int pr;
    int pc;
    found = 1'b0;
    r = 0;
    c = 0;
    while (!found) begin
      pr = pos_row;
      pc = pos_col;
      got = 1'b0;
      case (leg)
        LEG_DOWN_LEFT: begin
          if (pr < hub_row) begin
            pos_row = pr + 1; pos_col = pc - 1; got = 1'b1;
          end else leg = LEG_DOWN_RIGHT;
        end
        LEG_DOWN_RIGHT: begin
          if (pc < hub_col) begin
            pos_row = pr + 1; pos_col = pc + 1; got = 1'b1;
          end else leg = LEG_UP_RIGHT;
        end
        LEG_UP_RIGHT: begin
          if (pr > hub_row) begin
            pos_row = pr - 1; pos_col = pc + 1; got = 1'b1;
          end else leg = LEG_UP_LEFT;
        end
        default: begin
          if (pc > hub_col) begin
            pos_row = pr - 1; pos_col = pc - 1; got = 1'b1;
          end else begin
            pos_row = pr - 1; leg = LEG_DOWN_LEFT;
          end
        end
      endcase
      if (got && on_grid(pr, pc)) begin
        r = pr;
        c = pc;
        found = 1'b1;
      end
    end
  endtask

  task automatic predict_cell(input logic kind, input logic [6:0] cr, input logic [6:0] cc,
                              output cell_out_t outcome);
    int r;
    int c;
    int total;
    outcome = '0;
    if (kind == REQ_START) begin
      lat_rows = dim_limit(rows_reg);
      lat_cols = dim_limit(cols_reg);
      if (!on_grid(int'(cr), int'(cc))) begin
        walking = 1'b0;
        outcome.fault = 1'b1;
      end else begin
        total = lat_rows * lat_cols;
        hub_row = cr;
        hub_col = cc;
        pos_row = int'(cr) - 1;
        pos_col = cc;
        leg = LEG_DOWN_LEFT;
        emitted = 1;
        outcome.row = cr;
        outcome.col = cc;
        outcome.shown = 1'b1;
        outcome.last = (total <= 1);
        walking = (total > 1);
      end
    end else if (!walking) begin
      outcome.fault = 1'b1;
    end else begin
      step_walk(r, c);
      emitted++;
      outcome.row = r[6:0];
      outcome.col = c[6:0];
      outcome.shown = 1'b1;
      if (emitted >= lat_rows * lat_cols) begin
        outcome.last = 1'b1;
        walking = 1'b0;
      end
    end
  endtask

  task automatic queue_cell(cell_out_t item);
    expected_cells = {expected_cells, item};
  endtask

  task automatic report_miss(string msg);
    miss_count++;
    $display("[%0t] drco mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_miss($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  initial miss_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      rows_reg = 8'd1;
      cols_reg = 8'd1;
      lat_rows = 0;
      lat_cols = 0;
      pos_row = 0;
      pos_col = 0;
      hub_row = 0;
      hub_col = 0;
      emitted = 0;
      leg = LEG_DOWN_LEFT;
      walking = 1'b0;
      expected_cells.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (expected_cells.size() == 0) begin
          report_miss("result with no request waiting");
        end else begin
          head_cell = expected_cells.pop_front();
          check_field("cell_row", res.cell_row, head_cell.row);
          check_field("cell_col", res.cell_col, head_cell.col);
          check_field("cell_valid", res.cell_valid, head_cell.shown);
          check_field("last_cell", res.last_cell, head_cell.last);
          check_field("request_error", res.request_error, head_cell.fault);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_GRID_ROWS: rows_reg = cfg.data;
          REG_GRID_COLS: cols_reg = cfg.data;
        endcase
      end
      if (req.valid && req.ready) begin
        predict_cell(req.req_type, req.center_row, req.center_col, new_cell);
        queue_cell(new_cell);
      end
    end
    pending <= expected_cells.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for diamond_ring_cell_order: clock, reset, request and register
// stimulus, result stalls and the verdict. Depends on drco_pkg, drco_if, the
// block itself and drco_order_check.
module tb;
  import drco_pkg::*;

  localparam int RandomItems = 500;
  localparam int CalmTail    = 80;
  localparam int LimitCycles = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  drco_req_if req ();
  drco_res_if res ();
  drco_cfg_if cfg ();

  int fails;
  int pending;

  diamond_ring_cell_order uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg)
  );

  drco_order_check order_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .res     (res),
    .cfg     (cfg),
    .fails   (fails),
    .pending (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bit         idle_on;
  int         sink_hold;
  int         items_sent;
  int         walk_left;
  int         target;
  int         nr;
  int         nc;
  logic [7:0] rows_plan;
  logic [7:0] cols_plan;
  logic [6:0] r;
  logic [6:0] c;

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      res.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res.ready <= 1'b0;
      sink_hold = $urandom_range(0, 10);
    end else begin
      res.ready <= 1'b1;
    end
  end

  function automatic int plan_dim(logic [7:0] v);
    return (v > 8'd128) ? 128 : int'(v);
  endfunction

  function automatic logic [7:0] pick_dim();
    int k;
    k = $urandom_range(0, 19);
    if (k < 14) return 8'($urandom_range(1, 8));
    if (k < 16) return 8'($urandom_range(9, 16));
    if (k == 16) return 8'd1;
    if (k == 17) return 8'd128;
    if (k == 18) return 8'($urandom_range(129, 255));
    return 8'd0;
  endfunction

  task automatic send_req(logic kind, logic [6:0] row, logic [6:0] col);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.center_row <= row;
    req.center_col <= col;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic start_walk(logic [6:0] row, logic [6:0] col);
    int rows_use;
    int cols_use;
    rows_use = plan_dim(rows_plan);
    cols_use = plan_dim(cols_plan);
    send_req(REQ_START, row, col);
    walk_left = (row < rows_use && col < cols_use) ? rows_use * cols_use - 1 : 0;
  endtask

  task automatic step_next(int n);
    repeat (n) begin
      send_req(REQ_NEXT, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      if (walk_left > 0) walk_left--;
    end
  endtask

  // registers change only once every request has its result
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == REG_GRID_ROWS) rows_plan = val;
    else cols_plan = val;
  endtask

  initial begin
    req.valid      = 1'b0;
    req.req_type   = REQ_START;
    req.center_row = '0;
    req.center_col = '0;
    cfg.valid      = 1'b0;
    cfg.index      = REG_GRID_ROWS;
    cfg.data       = '0;
    res.ready      = 1'b0;
    idle_on        = 1'b1;
    sink_hold      = 0;
    items_sent     = 0;
    walk_left      = 0;
    rows_plan      = 8'd1;
    cols_plan      = 8'd1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // 1x1 after reset: lone cell, next with no walk, centre off grid
    start_walk(7'd0, 7'd0);
    step_next(1);
    start_walk(7'd127, 7'd127);
    step_next(1);
    // empty grid
    write_reg(REG_GRID_ROWS, 8'd0);
    start_walk(7'd0, 7'd0);
    // small grid walked to the end, one next past it
    write_reg(REG_GRID_ROWS, 8'd2);
    write_reg(REG_GRID_COLS, 8'd3);
    start_walk(7'd0, 7'd2);
    step_next(6);
    // walk abandoned by an off-grid start
    start_walk(7'd1, 7'd0);
    step_next(2);
    start_walk(7'd127, 7'd0);
    step_next(1);
    // oversized registers clamp to the full grid
    write_reg(REG_GRID_ROWS, 8'd255);
    write_reg(REG_GRID_COLS, 8'd128);
    start_walk(7'd127, 7'd127);
    step_next(3);
    start_walk(7'd0, 7'd0);
    step_next(2);

    target = items_sent + RandomItems;
    while (items_sent < target) begin
      idle_on = (items_sent < target - CalmTail) && ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 3))
        0: write_reg(REG_GRID_ROWS, pick_dim());
        1: write_reg(REG_GRID_COLS, pick_dim());
        default: begin
          write_reg(REG_GRID_ROWS, pick_dim());
          write_reg(REG_GRID_COLS, pick_dim());
        end
      endcase
      // resize under a running walk
      if (walk_left > 0 && $urandom_range(0, 1) == 1) step_next($urandom_range(1, 4));
      repeat ($urandom_range(1, 3)) begin
        nr = plan_dim(rows_plan);
        nc = plan_dim(cols_plan);
        if (nr == 0 || nc == 0 || $urandom_range(0, 7) == 0) begin
          r = 7'($urandom_range(0, 127));
          c = 7'($urandom_range(0, 127));
        end else begin
          r = 7'($urandom_range(0, nr - 1));
          c = 7'($urandom_range(0, nc - 1));
        end
        start_walk(r, c);
        if (walk_left <= 70 && $urandom_range(0, 3) != 0)
          step_next(walk_left + $urandom_range(0, 1));
        else
          step_next($urandom_range(0, (walk_left < 20) ? walk_left : 20));
      end
    end

    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("** diamond_ring_cell_order: PASSED **");
    end else begin
      $display("** diamond_ring_cell_order: FAILED **");
    end
    $finish;
  end

  initial begin
    #(LimitCycles * 8);
    $display("** diamond_ring_cell_order: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/drco_pkg.sv
rtl/drco_if.sv
rtl/drco_ctrl.sv
rtl/drco_dp.sv
rtl/diamond_ring_cell_order.sv
tb/sv/drco_order_check.sv
tb/sv/tb.sv
